### design/pexe_pkg.sv
// Shared types, token codes, precedence functions and sequencer states
// for the precedence expression evaluator. No dependencies.
package pexe_pkg;

  // Token kind as it arrives on the input channel (codes above KIND_END are invalid).
  typedef logic [3:0] kind_t;

  localparam kind_t KIND_NUM    = 4'd0;
  localparam kind_t KIND_LPAREN = 4'd1;
  localparam kind_t KIND_RPAREN = 4'd2;
  localparam kind_t KIND_EQ     = 4'd3;
  localparam kind_t KIND_NE     = 4'd4;
  localparam kind_t KIND_GE     = 4'd5;
  localparam kind_t KIND_GT     = 4'd6;
  localparam kind_t KIND_LE     = 4'd7;
  localparam kind_t KIND_LT     = 4'd8;
  localparam kind_t KIND_OR     = 4'd9;
  localparam kind_t KIND_AND    = 4'd10;
  localparam kind_t KIND_END    = 4'd11;

  // Completion status of one expression.
  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_OP_OVF    = 2'd1;
  localparam status_t STATUS_VAL_ERR   = 2'd2;
  localparam status_t STATUS_MALFORMED = 2'd3;

  typedef logic [3:0] prec_t;

  // Sequencer states of the shift-reduce engine.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP,
    ST_APPLY,
    ST_FINISH
  } state_t;

  // Precedence of an operator sitting on top of the stack.
  function automatic prec_t prec_f(kind_t k);
    prec_t p;
    case (k)
      KIND_NUM, KIND_RPAREN:                      p = 4'd8;
      KIND_EQ, KIND_NE, KIND_GE, KIND_GT,
      KIND_LE, KIND_LT:                           p = 4'd6;
      KIND_OR, KIND_AND:                          p = 4'd4;
      default:                                    p = 4'd0;
    endcase
    return p;
  endfunction

  // Precedence of an incoming token.
  function automatic prec_t prec_g(kind_t k);
    prec_t p;
    case (k)
      KIND_NUM, KIND_LPAREN:                      p = 4'd7;
      KIND_EQ, KIND_NE, KIND_GE, KIND_GT,
      KIND_LE, KIND_LT:                           p = 4'd5;
      KIND_OR, KIND_AND:                          p = 4'd3;
      default:                                    p = 4'd0;
    endcase
    return p;
  endfunction

  // True for the comparison and logical operators that consume two values.
  function automatic logic is_binary(kind_t k);
    return (k > KIND_RPAREN) && (k < KIND_END);
  endfunction

endpackage

### design/pexe_token_if.sv
// Input channel of the evaluator: one condition token per item.
// Depends on pexe_pkg for the token kind type.
interface pexe_token_if;
  logic                  valid;
  logic                  ready;
  pexe_pkg::kind_t       token_kind;
  logic signed [31:0]    token_value;
  logic                  negate;

  modport source(output valid, token_kind, token_value, negate, input ready);
  modport sink(input valid, token_kind, token_value, negate, output ready);
endinterface

### design/pexe_result_if.sv
// Output channel of the evaluator: one item per completed expression.
// Depends on pexe_pkg for the status type.
interface pexe_result_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    result_value;
  pexe_pkg::status_t     status;

  modport source(output valid, result_value, status, input ready);
  modport sink(input valid, result_value, status, output ready);
endinterface

### design/pexe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pexe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/pexe_alu.sv
// Comparison and logical unit: applies one binary operator to two stack values.
// Depends on pexe_pkg for the operator codes.
module pexe_alu #(
  parameter int VALUE_WIDTH = 32
) (
  input  pexe_pkg::kind_t         op,
  input  logic [VALUE_WIDTH-1:0]  a,
  input  logic [VALUE_WIDTH-1:0]  b,
  output logic                    r
);
  import pexe_pkg::*;

  logic signed [VALUE_WIDTH-1:0] sa;
  logic signed [VALUE_WIDTH-1:0] sb;

  assign sa = $signed(a);
  assign sb = $signed(b);

  // Relational operators compare as signed values; logical ones test for nonzero.
  always_comb begin
    case (op)
      KIND_EQ: r = (a == b);
      KIND_NE: r = (a != b);
      KIND_GE: r = (sa >= sb);
      KIND_GT: r = (sa > sb);
      KIND_LE: r = (sa <= sb);
      KIND_LT: r = (sa < sb);
      KIND_OR: r = (a != '0) || (b != '0);
      default: r = (a != '0) && (b != '0);
    endcase
  end

endmodule

### design/precedence_expression_evaluator_unit.sv
// Top level of the precedence expression evaluator: shift-reduce sequencer
// over operator and value stacks held in RAM. Depends on pexe_pkg,
// pexe_token_if, pexe_result_if, pexe_ram and pexe_alu.
//
// Usage:
//   Tokens enter on the token channel, one item per token. Number values are
//   already resolved. Nothing comes out until the end token, which yields one
//   item on the result channel with the value and a status, after which the
//   stacks are empty for the next expression. Invalid token kinds set the
//   malformed status and produce no item.
// Sequence:
//   A token is accepted in ST_IDLE and shifted in ST_DECIDE. Each reduction
//   pops with stack reads in ST_POP, then applies and writes back in
//   ST_APPLY, as the stack RAMs have registered read data, and each run of
//   reductions returns to ST_DECIDE to compare again. The end token then
//   passes through ST_FINISH for the result.
// Reset and stalls:
//   rst clears the counts, the error latch and the result register valid.
//   Stack contents are not cleared; entries above the counts are never used.
//   A pending result does not block new tokens; only a second end token waits
//   until the receiver takes the first result.
module precedence_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input logic           clk,
  input logic           rst,
  pexe_token_if.sink    token,
  pexe_result_if.source result
);
  import pexe_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Control state.
  state_t          state, state_next;
  logic [CW-1:0]   op_count, op_count_next;
  logic [CW-1:0]   val_count, val_count_next;
  status_t         error_seen, error_seen_next;
  logic            out_valid, out_valid_next;

  // Payload registers.
  kind_t                  kind, kind_next;
  logic [VALUE_WIDTH-1:0] val, val_next;
  kind_t                  op_top, op_top_next;
  logic [VALUE_WIDTH-1:0] val_top, val_top_next;
  kind_t                  pop_op, pop_op_next;
  logic [31:0]            out_value, out_value_next;
  status_t                out_status, out_status_next;

  // RAM ports.
  logic                   op_we;
  logic [AW-1:0]          op_waddr, op_raddr;
  kind_t                  op_wdata, op_rdata;
  logic                   val_we;
  logic [AW-1:0]          val_waddr, val_raddr;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

  // Helpers.
  logic [VALUE_WIDTH-1:0]    in_value;
  logic [VALUE_WIDTH-1:0]    in_prepared;
  logic                      alu_r;
  logic [VALUE_WIDTH-1:0]    alu_value;
  prec_t                     top_f;
  prec_t                     new_top_f;
  state_t                    exit_state;
  logic [VALUE_WIDTH+31:0]   result_ext;
  logic [CW-1:0]             op_count_m2;
  logic [CW-1:0]             val_count_m2;

  pexe_ram #(.WIDTH(4), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_waddr),
    .wdata (op_wdata),
    .raddr (op_raddr),
    .rdata (op_rdata)
  );

  pexe_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // The second operand comes from RAM, the top operand from its cache register.
  pexe_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
    .op (pop_op),
    .a  (val_rdata),
    .b  (val_top),
    .r  (alu_r)
  );

  // Sign-extend or truncate the incoming number, then apply the optional not.
  assign in_value    = VALUE_WIDTH'(token.token_value);
  assign in_prepared = token.negate ? {{(VALUE_WIDTH-1){1'b0}}, (in_value == '0)} : in_value;
  assign alu_value   = {{(VALUE_WIDTH-1){1'b0}}, alu_r};

  // Precedence of the current stack top, and of the entry that a pop exposes.
  assign top_f     = (op_count == '0) ? prec_f(KIND_END) : prec_f(op_top);
  assign new_top_f = (op_count == '0) ? prec_f(KIND_END) : prec_f(op_rdata);

  assign exit_state   = (kind == KIND_END) ? ST_FINISH : ST_IDLE;
  assign result_ext   = {32'd0, val_top};
  assign op_count_m2  = op_count - CW'(2);
  assign val_count_m2 = val_count - CW'(2);

  // Channel outputs.
  assign token.ready         = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.result_value = out_value;
  assign result.status       = out_status;

  // Sequencer: next state, stack accesses and result generation.
  // Only the reads issued in ST_POP are used, and no write happens in ST_POP, so
  // a used read never meets a write to the same entry in one cycle.
  always_comb begin
    state_next      = state;
    op_count_next   = op_count;
    val_count_next  = val_count;
    error_seen_next = error_seen;
    out_valid_next  = out_valid;
    kind_next       = kind;
    val_next        = val;
    op_top_next     = op_top;
    val_top_next    = val_top;
    pop_op_next     = pop_op;
    out_value_next  = out_value;
    out_status_next = out_status;
    op_we           = 1'b0;
    op_waddr        = op_count[AW-1:0];
    op_wdata        = kind;
    op_raddr        = op_count_m2[AW-1:0];
    val_we          = 1'b0;
    val_waddr       = val_count[AW-1:0];
    val_wdata       = val;
    val_raddr       = val_count_m2[AW-1:0];

    if (out_valid && result.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (token.valid) begin
          kind_next = token.token_kind;
          val_next  = in_prepared;
          if (token.token_kind > KIND_END) begin
            if (error_seen == STATUS_OK) begin
              error_seen_next = STATUS_MALFORMED;
            end
          end else if (token.token_kind == KIND_END) begin
            state_next = (error_seen == STATUS_OK) ? ST_DECIDE : ST_FINISH;
          end else if (error_seen == STATUS_OK) begin
            state_next = ST_DECIDE;
          end
        end
      end

      // Compare stack top against the incoming token: shift, finish the expression or start reducing.
      ST_DECIDE: begin
        if (kind == KIND_END && op_count == '0) begin
          state_next = ST_FINISH;
        end else if (top_f <= prec_g(kind)) begin
          if (kind == KIND_END) begin
            error_seen_next = STATUS_MALFORMED;
            state_next      = ST_FINISH;
          end else if (op_count >= CW'(STACK_DEPTH)) begin
            error_seen_next = STATUS_OP_OVF;
            state_next      = exit_state;
          end else begin
            op_we         = 1'b1;
            op_top_next   = kind;
            op_count_next = op_count + CW'(1);
            if (kind == KIND_NUM) begin
              if (val_count >= CW'(STACK_DEPTH)) begin
                error_seen_next = STATUS_VAL_ERR;
              end else begin
                val_we         = 1'b1;
                val_top_next   = val;
                val_count_next = val_count + CW'(1);
              end
            end
            state_next = exit_state;
          end
        end else begin
          state_next = ST_POP;
        end
      end

      // Pop the top operator and fetch the entries below both stack tops.
      ST_POP: begin
        if (op_count == '0) begin
          error_seen_next = STATUS_MALFORMED;
          state_next      = exit_state;
        end else begin
          pop_op_next   = op_top;
          op_count_next = op_count - CW'(1);
          if (is_binary(op_top) && val_count < CW'(2)) begin
            error_seen_next = STATUS_VAL_ERR;
            state_next      = exit_state;
          end else begin
            state_next = ST_APPLY;
          end
        end
      end

      // Apply the popped operator and decide whether to keep reducing.
      ST_APPLY: begin
        op_top_next = op_rdata;
        if (is_binary(pop_op)) begin
          val_we         = 1'b1;
          val_waddr      = val_count_m2[AW-1:0];
          val_wdata      = alu_value;
          val_top_next   = alu_value;
          val_count_next = val_count - CW'(1);
        end
        state_next = (new_top_f < prec_g(pop_op)) ? ST_DECIDE : ST_POP;
      end

      // Load the result register once it is free, then clear for the next expression.
      ST_FINISH: begin
        if (!out_valid || result.ready) begin
          out_valid_next = 1'b1;
          if (error_seen != STATUS_OK) begin
            out_status_next = error_seen;
            out_value_next  = '0;
          end else if (val_count == '0) begin
            out_status_next = STATUS_VAL_ERR;
            out_value_next  = '0;
          end else if (val_count > CW'(1)) begin
            out_status_next = STATUS_MALFORMED;
            out_value_next  = '0;
          end else begin
            out_status_next = STATUS_OK;
            out_value_next  = result_ext[31:0];
          end
          op_count_next   = '0;
          val_count_next  = '0;
          error_seen_next = STATUS_OK;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      op_count   <= '0;
      val_count  <= '0;
      error_seen <= STATUS_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      op_count   <= op_count_next;
      val_count  <= val_count_next;
      error_seen <= error_seen_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind       <= kind_next;
    val        <= val_next;
    op_top     <= op_top_next;
    val_top    <= val_top_next;
    pop_op     <= pop_op_next;
    out_value  <= out_value_next;
    out_status <= out_status_next;
  end

endmodule

### tb/sv/pexe_answer_checker.sv
`timescale 1ns / 1ps
// Checker for the precedence expression evaluator: watches the token and result
// channels, evaluates each expression on its own and compares every answer.
// Depends on pexe_pkg, pexe_token_if and pexe_result_if.
module pexe_answer_checker (
  input  logic   clk,
  input  logic   rst,
  pexe_token_if  token,
  pexe_result_if result,
  output int     mismatches,
  output int     answers_pending,
  output int     answers_checked,
  output int     error_answers
);
  import pexe_pkg::*;

  localparam int DEPTH = 16;

  // Precedence by token kind, kind 0 in the low nibble.
  localparam logic [47:0] STACKED_PREC = {4'd0, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6,
                                          4'd6, 4'd6, 4'd6, 4'd8, 4'd0, 4'd8};
  localparam logic [47:0] INCOMING_PREC = {4'd0, 4'd3, 4'd3, 4'd5, 4'd5, 4'd5,
                                           4'd5, 4'd5, 4'd5, 4'd0, 4'd7, 4'd7};

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } answer_t;

  kind_t       op_stack [DEPTH];
  logic [31:0] val_stack [DEPTH];
  int          op_cnt;
  int          val_cnt;
  status_t     err_latch;
  answer_t     answer_q [$];

  // Only the first error of an expression is kept.
  function automatic void latch_error(status_t code);
    if (err_latch == STATUS_OK) err_latch = code;
  endfunction

  function automatic logic [3:0] incoming_prec(kind_t k);
    return INCOMING_PREC[{k, 2'b00} +: 4];
  endfunction

  // An empty operator stack ranks like the end token.
  function automatic logic [3:0] top_prec();
    if (op_cnt == 0) return STACKED_PREC[{KIND_END, 2'b00} +: 4];
    return STACKED_PREC[{op_stack[op_cnt - 1], 2'b00} +: 4];
  endfunction

  function automatic bit push_val(logic [31:0] v);
    if (val_cnt >= DEPTH) begin
      latch_error(STATUS_VAL_ERR);
      return 1'b0;
    end
    val_stack[val_cnt] = v;
    val_cnt++;
    return 1'b1;
  endfunction

  // Pops two values, combines them with a comparison or logical operator.
  function automatic bit combine_top(kind_t op);
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic        r;
    if (val_cnt < 2) begin
      latch_error(STATUS_VAL_ERR);
      return 1'b0;
    end
    rhs = val_stack[val_cnt - 1];
    lhs = val_stack[val_cnt - 2];
    val_cnt -= 2;
    case (op)
      KIND_EQ: r = (lhs == rhs);
      KIND_NE: r = (lhs != rhs);
      KIND_GE: r = ($signed(lhs) >= $signed(rhs));
      KIND_GT: r = ($signed(lhs) > $signed(rhs));
      KIND_LE: r = ($signed(lhs) <= $signed(rhs));
      KIND_LT: r = ($signed(lhs) < $signed(rhs));
      KIND_OR: r = (lhs != 0) || (rhs != 0);
      default: r = (lhs != 0) && (rhs != 0);
    endcase
    return push_val({31'd0, r});
  endfunction

  // One shift-reduce pass for an incoming token.
  function automatic void shift_reduce(kind_t kind, logic [31:0] v);
    kind_t popped;
    while (1'b1) begin
      if (kind == KIND_END && op_cnt == 0) return;
      if (top_prec() <= incoming_prec(kind)) begin
        if (kind == KIND_END) begin
          latch_error(STATUS_MALFORMED);
          return;
        end
        if (op_cnt >= DEPTH) begin
          latch_error(STATUS_OP_OVF);
          return;
        end
        op_stack[op_cnt] = kind;
        op_cnt++;
        if (kind == KIND_NUM) void'(push_val(v));
        return;
      end
      // Reduce until the new stack top ranks below what was just popped.
      while (1'b1) begin
        if (op_cnt == 0) begin
          latch_error(STATUS_MALFORMED);
          return;
        end
        op_cnt--;
        popped = op_stack[op_cnt];
        if (popped > KIND_RPAREN && popped < KIND_END) begin
          if (!combine_top(popped)) return;
        end
        if (top_prec() < incoming_prec(popped)) break;
      end
    end
  endfunction

  // Applies one accepted token; the end token queues the expected answer.
  function automatic void evaluate_token(kind_t kind, logic [31:0] raw, logic neg);
    logic [31:0] v;
    answer_t     ans;
    v = neg ? {31'd0, raw == 0} : raw;
    if (kind > KIND_END) begin
      latch_error(STATUS_MALFORMED);
      return;
    end
    if (kind != KIND_END) begin
      if (err_latch == STATUS_OK) shift_reduce(kind, v);
      return;
    end
    ans.value = '0;
    if (err_latch == STATUS_OK) shift_reduce(KIND_END, '0);
    if (err_latch == STATUS_OK) begin
      if (val_cnt == 0) latch_error(STATUS_VAL_ERR);
      else if (val_cnt > 1) latch_error(STATUS_MALFORMED);
      else ans.value = val_stack[0];
    end
    ans.status = err_latch;
    if (err_latch != STATUS_OK) ans.value = '0;
    answer_q.push_back(ans);
    op_cnt = 0;
    val_cnt = 0;
    err_latch = STATUS_OK;
  endfunction

  // Results are checked before the token of the same edge; they never interact.
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      op_cnt = 0;
      val_cnt = 0;
      err_latch = STATUS_OK;
      answer_q.delete();
      mismatches = 0;
      answers_checked = 0;
      error_answers = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result: value %0d status %0d", $time,
                   result.result_value, result.status);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          answers_checked++;
          if (want.status != STATUS_OK) error_answers++;
          if (result.result_value !== want.value) begin
            $display("%0t: result_value mismatch: expected %0d, actual %0d", $time,
                     $signed(want.value), result.result_value);
            mismatches++;
          end
          if (result.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     want.status, result.status);
            mismatches++;
          end
        end
      end
      if (token.valid && token.ready)
        evaluate_token(token.token_kind, token.token_value, token.negate);
    end
    answers_pending = answer_q.size();
  end

endmodule

### tb/sv/precedence_expression_evaluator_unit_test.sv
`timescale 1ns / 1ps
// Top of the evaluator testbench: clock, reset, token stimulus, result back-pressure
// and the verdict. Depends on pexe_pkg, both channel interfaces and pexe_answer_checker.
module precedence_expression_evaluator_unit_test;
  import pexe_pkg::*;

  localparam kind_t KIND_LAST_CODE = 4'hF;
  localparam int    RANDOM_TOKENS  = 750;
  localparam int    TAIL_CYCLES    = 40;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        negate;
  } token_t;

  logic   clk = 1'b0;
  logic   rst;
  token_t expr_q [$];
  int     tokens_sent = 0;
  int     exprs_sent = 0;
  int     mismatches;
  int     answers_pending;
  int     answers_checked;
  int     error_answers;

  pexe_token_if  token_ch ();
  pexe_result_if result_ch ();

  precedence_expression_evaluator_unit dut (
    .clk    (clk),
    .rst    (rst),
    .token  (token_ch),
    .result (result_ch)
  );

  pexe_answer_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .token           (token_ch),
    .result          (result_ch),
    .mismatches      (mismatches),
    .answers_pending (answers_pending),
    .answers_checked (answers_checked),
    .error_answers   (error_answers)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle share in percent: light sender and heavy receiver stalls first,
  // then the reverse, then none at all.
  function automatic int idle_pct(bit receiver);
    if (tokens_sent < 250) return receiver ? 49 : 11;
    if (tokens_sent < 500) return receiver ? 11 : 49;
    return 0;
  endfunction

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
  end

  // Mostly small values so that comparisons often tie, plus the extremes.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'(int'($urandom_range(0, 6)) - 3);
      5:             return 32'h8000_0000;
      6:             return 32'h7fff_ffff;
      default:       return $urandom();
    endcase
  endfunction

  // Non-number tokens carry random payload that the block must ignore.
  function automatic void add_op(kind_t kind);
    token_t t;
    t.kind = kind;
    t.value = $urandom();
    t.negate = $urandom_range(0, 1);
    expr_q.push_back(t);
  endfunction

  function automatic void add_num(logic [31:0] value, logic neg);
    token_t t;
    t.kind = KIND_NUM;
    t.value = value;
    t.negate = neg;
    expr_q.push_back(t);
  endfunction

  // Well-formed expression: operands joined by random operators, with nesting.
  function automatic void gen_expr(int depth);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) add_op(kind_t'($urandom_range(KIND_EQ, KIND_AND)));
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
        add_op(KIND_LPAREN);
        gen_expr(depth - 1);
        add_op(KIND_RPAREN);
      end else begin
        add_num(rand_value(), $urandom_range(0, 4) == 0);
      end
    end
  endfunction

  task automatic send_token(token_t t);
    while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
      token_ch.valid <= 1'b0;
      @(posedge clk);
    end
    token_ch.valid       <= 1'b1;
    token_ch.token_kind  <= t.kind;
    token_ch.token_value <= t.value;
    token_ch.negate      <= t.negate;
    @(posedge clk);
    while (!token_ch.ready) @(posedge clk);
    tokens_sent++;
  endtask

  // Closes the pending expression with an end token and sends it.
  task automatic send_expr();
    add_op(KIND_END);
    foreach (expr_q[i]) send_token(expr_q[i]);
    expr_q.delete();
    exprs_sent++;
  endtask

  initial begin
    token_t t;
    int     start;
    int     n;
    int     idx;

    rst                  <= 1'b1;
    token_ch.valid       <= 1'b0;
    token_ch.token_kind  <= KIND_END;
    token_ch.token_value <= '0;
    token_ch.negate      <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Extreme operands, parentheses and a negated zero.
    add_op(KIND_LPAREN);
    add_num(32'h8000_0000, 1'b0);
    add_op(KIND_GT);
    add_num(32'h7fff_ffff, 1'b0);
    add_op(KIND_RPAREN);
    add_op(KIND_NE);
    add_num(32'd0, 1'b1);
    send_expr();
    // The remaining operators, mixing both precedence levels.
    add_num(32'hffff_ffff, 1'b0);
    add_op(KIND_GE);
    add_num(32'd0, 1'b0);
    add_op(KIND_EQ);
    add_num(32'd1, 1'b0);
    add_op(KIND_OR);
    add_num(32'h7fff_ffff, 1'b0);
    add_op(KIND_LT);
    add_num(32'hffff_ffff, 1'b0);
    add_op(KIND_AND);
    add_num(32'd0, 1'b0);
    add_op(KIND_LE);
    add_num(32'd1, 1'b0);
    send_expr();
    // Empty expression, operator without operands, stray closing parenthesis.
    send_expr();
    add_op(KIND_EQ);
    send_expr();
    add_op(KIND_RPAREN);
    send_expr();
    // Unknown kind latches an error; the number after it is ignored.
    add_op(kind_t'($urandom_range(KIND_END + 1, KIND_LAST_CODE)));
    add_num(32'd1, 1'b0);
    send_expr();

    start = tokens_sent;
    while (tokens_sent - start < RANDOM_TOKENS) begin
      case ($urandom_range(0, 99)) inside
        [0:69]: gen_expr(3);
        [70:79]: begin
          // Well-formed expression with one token dropped or one inserted.
          gen_expr(3);
          idx = $urandom_range(0, expr_q.size() - 1);
          if ($urandom_range(0, 1) == 0) begin
            expr_q.delete(idx);
          end else begin
            t.kind = kind_t'($urandom_range(KIND_NUM, KIND_END));
            t.value = rand_value();
            t.negate = $urandom_range(0, 1);
            expr_q.insert(idx, t);
          end
        end
        [80:91]: begin
          // Noise, unknown kinds included.
          n = $urandom_range(0, 6);
          repeat (n) begin
            t.kind = kind_t'($urandom_range(KIND_NUM, KIND_LAST_CODE));
            t.value = rand_value();
            t.negate = $urandom_range(0, 1);
            expr_q.push_back(t);
          end
        end
        [92:95]: begin
          // Deep nesting around the operator stack limit.
          n = $urandom_range(13, 17);
          repeat (n) add_op(KIND_LPAREN);
          add_num(rand_value(), $urandom_range(0, 1));
          repeat (n) add_op(KIND_RPAREN);
        end
        default: begin
          // A run of bare numbers around the value stack limit.
          n = $urandom_range(13, 18);
          repeat (n) add_num(rand_value(), $urandom_range(0, 1));
        end
      endcase
      send_expr();
    end
    token_ch.valid <= 1'b0;

    // Drain outstanding answers, then allow the longest reduction chain to finish.
    @(posedge clk);
    while (answers_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d tokens in %0d expressions under three idle patterns.",
             tokens_sent, exprs_sent);
    $display("Checked %0d results, %0d of them with an error status.",
             answers_checked, error_answers);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout: %0d answers still pending", answers_pending);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
design/pexe_pkg.sv
design/pexe_token_if.sv
design/pexe_result_if.sv
design/pexe_ram.sv
design/pexe_alu.sv
design/precedence_expression_evaluator_unit.sv
tb/sv/pexe_answer_checker.sv
tb/sv/precedence_expression_evaluator_unit_test.sv
